@@ design/fifo_with_priority_promotion_defines.svh @@
// Assertion macros for the queue design files.
// No dependencies; included by files that carry concurrent checks.
`ifndef FIFO_WITH_PRIORITY_PROMOTION_DEFINES_SVH
`define FIFO_WITH_PRIORITY_PROMOTION_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FWPP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FWPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/fwpp_pkg.sv @@
// Shared constants, codes and types for the priority-promotion queue.
// No dependencies; used by the controller and the top level of the block.
`timescale 1ns / 1ps

package fwpp_pkg;

   // Fixed field widths of the request and response channels.
   localparam int KIND_W   = 2;
   localparam int IDENT_W  = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   // Default sizing.
   localparam int DEPTH_DEF   = 16;
   localparam int ID_BITS_DEF = 16;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_ENQ    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEQ    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_URGENT = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   // One finished response as handed from the controller to the output stage.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDENT_W-1:0]  head_ident;
      logic [OCC_W-1:0]    occupancy;
   } rsp_type;

endpackage

@@ design/fwpp_mem.sv @@
// Entry store of the queue: one write port, one read port, registered read data.
// Depends on nothing; instantiated by the top level.
`timescale 1ns / 1ps

module fwpp_mem #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Synchronous write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   // Synchronous read; the read data is registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/fwpp_ctrl.sv @@
// Sequencer of the queue: decodes a request, walks the entry store for
// search and gap closing, and keeps head and count. Depends on fwpp_pkg and the defines header.
`timescale 1ns / 1ps
`include "fifo_with_priority_promotion_defines.svh"

module fwpp_ctrl #(
   parameter int DEPTH = 16,
   parameter int IW    = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [fwpp_pkg::KIND_W-1:0] req_kind,
   input  logic [IW-1:0]               req_id,
   input  logic                        slot_free,
   output logic                        done,
   output fwpp_pkg::rsp_type           result,
   output logic                        mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]    mem_wr_addr,
   output logic [IW-1:0]               mem_wr_data,
   output logic                        mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]    mem_rd_addr,
   input  logic [IW-1:0]               mem_rd_data
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = CW + 1;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_EXEC     = 3'd1;
   localparam logic [2:0] S_DEQ_WAIT = 3'd2;
   localparam logic [2:0] S_SCAN     = 3'd3;
   localparam logic [2:0] S_SHIFT    = 3'd4;
   localparam logic [2:0] S_PLACE    = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0]                    state_ff, state_in;
   logic [fwpp_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic [IW-1:0]                 id_ff, id_in;
   logic [AW-1:0]                 head_ff, head_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [fwpp_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [IW-1:0]                 taken_ff, taken_in;

   logic [PW-1:0] pos_nx;
   logic [PW-1:0] pos_nx2;
   logic [PW-1:0] count_ext;
   logic          is_full;
   logic          is_empty;
   logic [AW-1:0] head_inc;
   logic [AW-1:0] head_dec;

   // Physical slot of a position counted from the head, wrapping at DEPTH.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [AW-1:0] pos);
      logic [AW:0] sum;
      sum = {1'b0, head} + {1'b0, pos};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // Helper values for the next-state logic.
   assign pos_nx    = PW'(pos_ff) + PW'(1);
   assign pos_nx2   = PW'(pos_ff) + PW'(2);
   assign count_ext = PW'(count_ff);
   assign is_full   = (count_ff >= CW'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign head_inc  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);

   // Next-state and store access logic.
   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      id_in       = id_ff;
      head_in     = head_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      status_in   = status_ff;
      taken_in    = taken_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = id_ff;
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      done        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_kind;
               id_in     = req_id;
               status_in = fwpp_pkg::ST_OK;
               taken_in  = '0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (kind_ff)
               fwpp_pkg::KIND_ENQ: begin
                  if (is_full) begin
                     status_in = fwpp_pkg::ST_FULL;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = slot_of(head_ff, AW'(count_ff));
                     count_in    = count_ff + CW'(1);
                  end
                  state_in = S_FINISH;
               end
               fwpp_pkg::KIND_DEQ: begin
                  if (is_empty) begin
                     status_in = fwpp_pkg::ST_EMPTY;
                     state_in  = S_FINISH;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = head_ff;
                     state_in    = S_DEQ_WAIT;
                  end
               end
               fwpp_pkg::KIND_URGENT: begin
                  pos_in = '0;
                  if (is_empty) begin
                     state_in = S_PLACE;
                  end else begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = head_ff;
                     state_in    = S_SCAN;
                  end
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_DEQ_WAIT: begin
            taken_in = mem_rd_data;
            head_in  = head_inc;
            count_in = count_ff - CW'(1);
            state_in = S_FINISH;
         end
         S_SCAN: begin
            // Compare the entry read last cycle; fetch the next one meanwhile.
            if (mem_rd_data == id_ff) begin
               if (pos_nx < count_ext) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = slot_of(head_ff, AW'(pos_nx));
                  state_in    = S_SHIFT;
               end else begin
                  count_in = count_ff - CW'(1);
                  state_in = S_PLACE;
               end
            end else if (pos_nx < count_ext) begin
               pos_in      = AW'(pos_nx);
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot_of(head_ff, AW'(pos_nx));
            end else begin
               state_in = S_PLACE;
            end
         end
         S_SHIFT: begin
            // Move the entry behind the gap forward by one position.
            mem_wr_en   = 1'b1;
            mem_wr_addr = slot_of(head_ff, pos_ff);
            mem_wr_data = mem_rd_data;
            if (pos_nx2 < count_ext) begin
               pos_in      = AW'(pos_nx);
               mem_rd_en   = 1'b1;
               mem_rd_addr = slot_of(head_ff, AW'(pos_nx2));
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            if (is_full) begin
               status_in = fwpp_pkg::ST_FULL;
            end else begin
               head_in     = head_dec;
               mem_wr_en   = 1'b1;
               mem_wr_addr = head_dec;
               count_in    = count_ff + CW'(1);
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Working registers of the current request.
   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      id_ff     <= id_in;
      pos_ff    <= pos_in;
      status_ff <= status_in;
      taken_ff  <= taken_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign result.status     = status_ff;
   assign result.head_ident = fwpp_pkg::IDENT_W'(taken_ff);
   assign result.occupancy  = fwpp_pkg::OCC_W'(count_ff);

   // The count never exceeds the capacity.
   `FWPP_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH), "count over depth")
   // A write and a read never touch the same entry in one cycle.
   `FWPP_ASSERT_NOW(a_no_rw_clash, clock, reset, mem_wr_en && mem_rd_en, mem_wr_addr != mem_rd_addr, "read and write to same entry")
   // A response is only handed over when the output stage can take it.
   `FWPP_ASSERT_NOW(a_done_free, clock, reset, done, slot_free && state_ff == S_FINISH, "response issued while output busy")
   // An accepted request always starts execution.
   `FWPP_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == S_EXEC, "accepted request not executed")

endmodule

@@ design/fifo_with_priority_promotion.sv @@
// Top level of the bounded request queue with urgent move-to-front insert.
// Depends on fwpp_pkg, fwpp_mem and fwpp_ctrl.
//
//   Channel  Handshake              Payload
//   req_     req_valid/req_ready    req_kind, req_ident
//   rsp_     rsp_valid/rsp_ready    rsp_status, rsp_head_ident, rsp_occupancy
//
// Enqueue and unused kinds go from acceptance through execute to finish;
// dequeue also waits for its read data, and an urgent insert walks the
// held entries: the search and the gap closing share one pass over the
// store, one entry a cycle through its single read port.
// Reset empties the queue at once; the store needs no clearing pass.
// A new request is accepted while a finished response waits in the output
// register; a stalled response holds the sequencer only at its final step.
`timescale 1ns / 1ps

module fifo_with_priority_promotion #(
   parameter int DEPTH   = fwpp_pkg::DEPTH_DEF,
   parameter int ID_BITS = fwpp_pkg::ID_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [fwpp_pkg::KIND_W-1:0]   req_kind,
   input  logic [fwpp_pkg::IDENT_W-1:0]  req_ident,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [fwpp_pkg::STATUS_W-1:0] rsp_status,
   output logic [fwpp_pkg::IDENT_W-1:0]  rsp_head_ident,
   output logic [fwpp_pkg::OCC_W-1:0]    rsp_occupancy
);

   // Stored identifier width: the port carries at most IDENT_W bits.
   localparam int IW = (ID_BITS < fwpp_pkg::IDENT_W) ? ID_BITS : fwpp_pkg::IDENT_W;
   localparam int AW = $clog2(DEPTH);

   logic                 slot_free;
   logic                 done;
   fwpp_pkg::rsp_type    result;
   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [IW-1:0]        mem_wr_data;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [IW-1:0]        mem_rd_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   fwpp_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   fwpp_ctrl #(
      .DEPTH (DEPTH),
      .IW    (IW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_kind    (req_kind),
      .req_id      (req_ident[IW-1:0]),
      .slot_free   (slot_free),
      .done        (done),
      .result      (result),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   fwpp_mem #(
      .DEPTH (DEPTH),
      .WIDTH (IW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Output register: loads a finished response, clears when it is taken.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_data_ff.status;
   assign rsp_head_ident = rsp_data_ff.head_ident;
   assign rsp_occupancy  = rsp_data_ff.occupancy;

endmodule

@@ test/fwpp_queue_checker.sv @@
// Checker for the priority-promotion queue: watches both channels, predicts each response.
// Depends on fwpp_pkg; instantiated beside the block by the testbench top.
`timescale 1ns / 1ps

module fwpp_queue_checker
   import fwpp_pkg::*;
#(
   parameter int DEPTH   = DEPTH_DEF,
   parameter int ID_BITS = ID_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [IDENT_W-1:0]  req_ident,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [STATUS_W-1:0] rsp_status,
   input  logic [IDENT_W-1:0]  rsp_head_ident,
   input  logic [OCC_W-1:0]    rsp_occupancy,
   output int                  error_count,
   output int                  pending,
   output int                  checked_count,
   output int                  full_count,
   output int                  empty_count,
   output int                  promoted_count
);

   localparam logic [IDENT_W-1:0] ID_MASK =
      (ID_BITS >= IDENT_W) ? {IDENT_W{1'b1}} : IDENT_W'((64'd1 << ID_BITS) - 1);

   // Identifiers held by the queue, oldest first.
   logic [IDENT_W-1:0] held_ids[$];
   // Responses still owed by the block, oldest first.
   rsp_type pending_responses[$];

   // Apply one request to the queue contents and return the response it earns.
   function automatic rsp_type apply_request(input logic [KIND_W-1:0]  kind,
                                             input logic [IDENT_W-1:0] ident);
      rsp_type            result;
      logic [IDENT_W-1:0] id;
      int                 pos;
      result        = '0;
      result.status = ST_OK;
      id            = ident & ID_MASK;
      pos           = -1;
      case (kind)
         KIND_ENQ: begin
            if (held_ids.size() >= DEPTH) begin
               result.status = ST_FULL;
               full_count++;
            end else begin
               held_ids.push_back(id);
            end
         end
         KIND_DEQ: begin
            if (held_ids.size() == 0) begin
               result.status = ST_EMPTY;
               empty_count++;
            end else begin
               result.head_ident = held_ids.pop_front();
            end
         end
         KIND_URGENT: begin
            // Drop the first held copy counted from the head, then retry for room.
            foreach (held_ids[i]) begin
               if (pos < 0 && held_ids[i] == id) pos = i;
            end
            if (pos >= 0) begin
               held_ids.delete(pos);
               promoted_count++;
            end
            if (held_ids.size() >= DEPTH) begin
               result.status = ST_FULL;
               full_count++;
            end else begin
               held_ids.push_front(id);
            end
         end
         default: ;
      endcase
      result.occupancy = OCC_W'(held_ids.size());
      return result;
   endfunction

   // Responses are matched before the request of the same cycle is predicted;
   // the block can never answer a request in the cycle it accepts it.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         held_ids.delete();
         pending_responses.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.status     = rsp_status;
            got.head_ident = rsp_head_ident;
            got.occupancy  = rsp_occupancy;
            if (pending_responses.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual status %0d head %h occupancy %0d",
                        $time, got.status, got.head_ident, got.occupancy);
               error_count++;
            end else begin
               want = pending_responses.pop_front();
               checked_count++;
               if (got.status !== want.status || got.head_ident !== want.head_ident ||
                   got.occupancy !== want.occupancy) begin
                  $display("%0t: response %0d: expected status %0d head %h occupancy %0d, actual status %0d head %h occupancy %0d",
                           $time, checked_count, want.status, want.head_ident, want.occupancy,
                           got.status, got.head_ident, got.occupancy);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_responses.push_back(apply_request(req_kind, req_ident));
         end
      end
      pending = pending_responses.size();
   end

endmodule

@@ test/testbench.sv @@
// Top of the priority-promotion queue testbench: clock, reset, request stimulus, verdict.
// Depends on fwpp_pkg, the block fifo_with_priority_promotion and fwpp_queue_checker.
`timescale 1ns / 1ps

module testbench;
   import fwpp_pkg::*;

   // The block takes no action on this kind code.
   localparam logic [KIND_W-1:0] KIND_IDLE = 2'd3;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind = KIND_ENQ;
   logic [IDENT_W-1:0]  req_ident = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [IDENT_W-1:0]  rsp_head_ident;
   logic [OCC_W-1:0]    rsp_occupancy;

   int error_count;
   int pending;
   int checked_count;
   int full_count;
   int empty_count;
   int promoted_count;
   int request_count = 0;
   bit stalls_on = 1'b1;

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   fifo_with_priority_promotion i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_ident      (req_ident),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_head_ident (rsp_head_ident),
      .rsp_occupancy  (rsp_occupancy)
   );

   fwpp_queue_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_ident      (req_ident),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_head_ident (rsp_head_ident),
      .rsp_occupancy  (rsp_occupancy),
      .error_count    (error_count),
      .pending        (pending),
      .checked_count  (checked_count),
      .full_count     (full_count),
      .empty_count    (empty_count),
      .promoted_count (promoted_count)
   );

   // Pause length in cycles: mostly none or short, now and then long.
   function automatic int random_pause();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Present one request after an optional idle gap and hold it until accepted.
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [IDENT_W-1:0] ident,
                               input int gap);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_kind  = kind;
      req_ident = ident;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      request_count++;
   endtask

   // Response side: ready runs of random length broken by random stalls.
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else if (!stalls_on || $urandom_range(0, 3) != 0) begin
            rsp_ready = 1'b1;
            hold = $urandom_range(0, 7);
         end else begin
            rsp_ready = 1'b0;
            hold = random_pause();
         end
      end
   end

   // Stimulus: directed corner cases, then random phases with a drift in occupancy.
   initial begin
      int                 phase_bias;
      int                 pick;
      bit                 quiet;
      logic [KIND_W-1:0]  kind;
      logic [IDENT_W-1:0] ident;
      logic [IDENT_W-1:0] pool_base;

      repeat (10) @(negedge clock);
      reset = 1'b0;

      // Empty dequeue, extreme identifiers, promotion of a held copy, idle kind.
      send_request(KIND_DEQ, 16'h0000, 0);
      send_request(KIND_ENQ, 16'h0000, 0);
      send_request(KIND_ENQ, 16'hFFFF, random_pause());
      send_request(KIND_URGENT, 16'hFFFF, 0);
      send_request(KIND_IDLE, 16'hA5A5, 0);
      send_request(KIND_DEQ, 16'h5A5A, 0);
      // Fill to capacity, then push against the full queue.
      for (int i = 0; i < DEPTH_DEF - 1; i++) begin
         send_request(KIND_ENQ, 16'h1000 + 16'(i), random_pause());
      end
      send_request(KIND_ENQ, 16'hBEEF, 0);
      send_request(KIND_URGENT, 16'h5555, 0);
      send_request(KIND_URGENT, 16'h1007, 0);
      send_request(KIND_DEQ, 16'h0000, 0);
      send_request(KIND_URGENT, 16'h0000, 0);
      send_request(KIND_URGENT, 16'h2222, 0);

      // Random phases of 40 requests, each with its own mix, pool and pacing.
      while (request_count < 1050) begin
         phase_bias = $urandom_range(0, 2);
         quiet      = ($urandom_range(0, 3) == 0);
         stalls_on  = ($urandom_range(0, 3) != 0);
         pool_base  = IDENT_W'($urandom);
         for (int n = 0; n < 40; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               kind = KIND_IDLE;
            end else if (phase_bias == 0) begin
               kind = (pick < 58) ? KIND_ENQ : (pick < 83) ? KIND_URGENT : KIND_DEQ;
            end else if (phase_bias == 1) begin
               kind = (pick < 63) ? KIND_DEQ : (pick < 83) ? KIND_ENQ : KIND_URGENT;
            end else begin
               kind = (pick < 38) ? KIND_ENQ : (pick < 73) ? KIND_DEQ : KIND_URGENT;
            end
            // A small pool of identifiers makes duplicates common for urgent inserts.
            if ($urandom_range(0, 3) != 0) begin
               ident = pool_base ^ IDENT_W'($urandom_range(0, 7));
            end else begin
               ident = IDENT_W'($urandom_range(0, 16'hFFFF));
            end
            send_request(kind, ident, quiet ? 0 : random_pause());
         end
      end
      stalls_on = 1'b1;
      @(negedge clock);
      req_valid = 1'b0;

      // Drain every owed response, then give the block time to show stray ones.
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Sent %0d requests and checked %0d responses.", request_count, checked_count);
      $display("Saw %0d full and %0d empty refusals and %0d urgent promotions of a held copy.",
               full_count, empty_count, promoted_count);
      if (error_count == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Hard stop in case the block hangs.
   initial begin
      #1_500_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
